// ===== design/assert_macros.svh =====
// assertion macros shared by stl_core and stl_fifo
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define STL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("check failed");
`define STL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("check failed");
`else
`define STL_ASSERT(lbl, clk, rst_n, prop)
`define STL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== design/stl_pkg.sv =====
`timescale 1ns / 1ps
package stl_pkg;

  localparam int LEN_W       = 16;
  localparam int UNIT_W      = 16;
  localparam int TOK_LEN_W   = 16;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef enum logic [3:0] {
    K_UNKNOWN = 4'd0,
    K_LINE    = 4'd1,
    K_BLOCK   = 4'd2,
    K_SPACE   = 4'd3,
    K_IDENT   = 4'd4,
    K_PREFIX  = 4'd5,
    K_LIT     = 4'd6,
    K_SEMI    = 4'd7,
    K_COMMA   = 4'd8,
    K_OPEN    = 4'd9,
    K_CLOSE   = 4'd10,
    K_EQ      = 4'd11
  } kind_t;

  typedef enum logic [7:0] {
    M_IDLE       = 8'b0000_0001,
    M_SLASH      = 8'b0000_0010,
    M_LINE       = 8'b0000_0100,
    M_BLOCK      = 8'b0000_1000,
    M_BLOCK_STAR = 8'b0001_0000,
    M_SPACE      = 8'b0010_0000,
    M_IDENT      = 8'b0100_0000,
    M_LIT        = 8'b1000_0000
  } mode_t;

  localparam logic [UNIT_W-1:0] CH_LF     = 16'h000A;
  localparam logic [UNIT_W-1:0] CH_SLASH  = 16'h002F;
  localparam logic [UNIT_W-1:0] CH_STAR   = 16'h002A;
  localparam logic [UNIT_W-1:0] CH_HASH   = 16'h0023;
  localparam logic [UNIT_W-1:0] CH_DQUOTE = 16'h0022;
  localparam logic [UNIT_W-1:0] CH_SQUOTE = 16'h0027;
  localparam logic [UNIT_W-1:0] CH_UNDER  = 16'h005F;
  localparam logic [UNIT_W-1:0] CH_SEMI   = 16'h003B;
  localparam logic [UNIT_W-1:0] CH_COMMA  = 16'h002C;
  localparam logic [UNIT_W-1:0] CH_OPEN   = 16'h0028;
  localparam logic [UNIT_W-1:0] CH_CLOSE  = 16'h0029;
  localparam logic [UNIT_W-1:0] CH_EQ     = 16'h003D;

  typedef struct packed {
    kind_t                kind;
    logic [TOK_LEN_W-1:0] len;
    logic                 last;
  } stl_res_t;

  typedef struct packed {
    logic     push0;
    logic     push1;
    stl_res_t res0;
    stl_res_t res1;
  } stl_push_t;

  typedef struct packed {
    mode_t mode;
    logic  emit;
    kind_t kind;
  } stl_start_t;

  function automatic logic is_space(input logic [UNIT_W-1:0] c);
    return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
           c == 16'h200E || c == 16'h200F || c == 16'h2028 || c == 16'h2029;
  endfunction

  function automatic logic is_word(input logic [UNIT_W-1:0] c);
    return (c >= 16'h0061 && c <= 16'h007A) || (c >= 16'h0041 && c <= 16'h005A) ||
           (c >= 16'h4E00 && c <= 16'h9FFF) || (c >= 16'h3400 && c <= 16'h4DBF) ||
           (c >= 16'hD83C && c <= 16'hDBFF) || (c >= 16'hDC00 && c <= 16'hDFFF);
  endfunction

  function automatic logic is_digit(input logic [UNIT_W-1:0] c);
    return c >= 16'h0030 && c <= 16'h0039;
  endfunction

  // what a unit does when it opens a new token
  function automatic stl_start_t start_of(input logic [UNIT_W-1:0] c);
    stl_start_t s;
    s.mode = M_IDLE;
    s.emit = 1'b0;
    s.kind = K_UNKNOWN;
    if (c == CH_SLASH) begin
      s.mode = M_SLASH;
    end else if (is_space(c)) begin
      s.mode = M_SPACE;
    end else if (c == CH_UNDER || is_word(c)) begin
      s.mode = M_IDENT;
    end else if (is_digit(c)) begin
      s.mode = M_LIT;
    end else begin
      s.emit = 1'b1;
      if (c == CH_SEMI) s.kind = K_SEMI;
      else if (c == CH_COMMA) s.kind = K_COMMA;
      else if (c == CH_OPEN) s.kind = K_OPEN;
      else if (c == CH_CLOSE) s.kind = K_CLOSE;
      else if (c == CH_EQ) s.kind = K_EQ;
      else s.kind = K_UNKNOWN;
    end
    return s;
  endfunction

endpackage

// ===== design/stl_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stl_core
  import stl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [UNIT_W-1:0] unit,
  input  logic              eoi,
  output stl_push_t         push
);

  mode_t             mode_r, mode_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  grown;
  stl_start_t        st;
  logic              a_v, b_v, use_start;
  kind_t             a_kind;
  logic [LEN_W-1:0]  a_len;
  stl_res_t          ra, rb;

  assign grown = (len_r == LEN_MAX) ? len_r : len_r + 1'b1;
  assign st    = start_of(unit);

  always_comb begin
    a_v       = 1'b0;
    a_kind    = K_UNKNOWN;
    a_len     = len_r;
    use_start = 1'b0;
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    if (eoi) begin
      mode_nxt = M_IDLE;
      len_nxt  = '0;
      a_v      = (mode_r != M_IDLE);
      unique case (mode_r)
        M_SLASH:                a_kind = K_UNKNOWN;
        M_LINE:                 a_kind = K_LINE;
        M_BLOCK, M_BLOCK_STAR:  a_kind = K_BLOCK;
        M_SPACE:                a_kind = K_SPACE;
        M_IDENT:                a_kind = K_IDENT;
        M_LIT:                  a_kind = K_LIT;
        default:                a_kind = K_UNKNOWN;
      endcase
    end else begin
      unique case (mode_r)
        M_SLASH: begin
          if (unit == CH_SLASH) begin
            mode_nxt = M_LINE;
            len_nxt  = grown;
          end else if (unit == CH_STAR) begin
            mode_nxt = M_BLOCK;
            len_nxt  = grown;
          end else begin
            a_v       = 1'b1;
            a_kind    = K_UNKNOWN;
            use_start = 1'b1;
          end
        end
        M_LINE: begin
          if (unit == CH_LF) begin
            a_v       = 1'b1;
            a_kind    = K_LINE;
            use_start = 1'b1;
          end else begin
            len_nxt = grown;
          end
        end
        M_BLOCK: begin
          len_nxt = grown;
          if (unit == CH_STAR) mode_nxt = M_BLOCK_STAR;
        end
        M_BLOCK_STAR: begin
          len_nxt = grown;
          if (unit == CH_SLASH) begin
            a_v      = 1'b1;
            a_kind   = K_BLOCK;
            a_len    = grown;
            mode_nxt = M_IDLE;
            len_nxt  = '0;
          end else if (unit != CH_STAR) begin
            mode_nxt = M_BLOCK;
          end
        end
        M_SPACE: begin
          if (is_space(unit)) begin
            len_nxt = grown;
          end else begin
            a_v       = 1'b1;
            a_kind    = K_SPACE;
            use_start = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_word(unit)) begin
            len_nxt = grown;
          end else begin
            a_v       = 1'b1;
            a_kind    = (unit == CH_HASH || unit == CH_DQUOTE || unit == CH_SQUOTE) ?
                        K_PREFIX : K_IDENT;
            use_start = 1'b1;
          end
        end
        M_LIT: begin
          if (is_digit(unit)) begin
            len_nxt = grown;
          end else begin
            a_v       = 1'b1;
            a_kind    = K_LIT;
            use_start = 1'b1;
          end
        end
        default: use_start = 1'b1;
      endcase
      if (use_start) begin
        mode_nxt = st.mode;
        len_nxt  = st.emit ? LEN_W'(0) : LEN_W'(1);
      end
    end
  end

  assign b_v = use_start & st.emit;

  always_comb begin
    ra.kind = a_kind;
    ra.len  = TOK_LEN_W'(a_len);
    ra.last = ~b_v;
    rb.kind = st.kind;
    rb.len  = TOK_LEN_W'(1);
    rb.last = 1'b1;
    push.push0 = fire & (a_v | b_v);
    push.push1 = fire & a_v & b_v;
    push.res0  = a_v ? ra : rb;
    push.res1  = rb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      len_r  <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
    end
  end

  `STL_ASSERT(a_flush_idle, clk, rst_n, fire && eoi |=> mode_r == M_IDLE && len_r == '0)
  `STL_ASSERT(a_idle_len, clk, rst_n, (mode_r == M_IDLE) == (len_r == '0))

endmodule

// ===== design/stl_fifo.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stl_fifo
  import stl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  stl_push_t push,
  output logic      room,
  output logic      rd_valid,
  input  logic      rd_ready,
  output stl_res_t  rd_data
);

  stl_res_t           mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               pop;

  assign room     = (cnt_r <= FIFO_CW'(FIFO_DEPTH - 2));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem[rd_ptr_r];
  assign pop      = rd_valid & rd_ready;
  assign cnt_nxt  = cnt_r + FIFO_CW'(push.push0) + FIFO_CW'(push.push1) - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (push.push0) mem[wr_ptr_r] <= push.res0;
    if (push.push1) mem[wr_ptr_r + 1'b1] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(push.push0) + FIFO_AW'(push.push1);
      rd_ptr_r <= rd_ptr_r + FIFO_AW'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  `STL_ASSERT(a_no_overflow, clk, rst_n, cnt_r <= FIFO_CW'(FIFO_DEPTH))
  `STL_ASSERT(a_push_order, clk, rst_n, push.push1 |-> push.push0)

endmodule

// ===== design/source_tokenizer.sv =====
`timescale 1ns / 1ps
// source_tokenizer: streaming lexer, one 16-bit code unit per input word.
// input channel: in_tdata carries the code unit, in_tuser set means end of
// input (no character, the pending token is flushed and the lexer goes idle).
// output channel: one word per token, out_tdata = token length (saturating),
// out_tuser = token kind, out_tlast marks the last token caused by one input.
// an input word causes zero, one or two tokens; tokens that need lookahead
// come out when the unit that ends them arrives.
// a token caused by an input word goes from the input register through the
// lexer step into the result queue; the lexer step waits while the queue lacks
// room, and the token reaches the output behind any tokens still queued.
// throughput: one input word per cycle while the output drains one token per
// cycle; a word causing two tokens needs two output transfers. the four-entry
// result queue takes a word only while two free slots are available.
// reset: synchronous, active low; clears the lexer to idle, empties the queue.
// when the receiver stalls, the queue fills and in_tready drops; nothing is
// lost and the output word holds steady until taken.
module source_tokenizer
  import stl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [UNIT_W-1:0]    in_tdata,   // [15:0] code_unit
  input  logic                 in_tuser,   // [0] end_of_input
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [TOK_LEN_W-1:0] out_tdata,  // [15:0] token_length
  output logic [3:0]           out_tuser,  // [3:0] tok_kind
  output logic                 out_tlast
);

  logic              in_valid_r;
  logic [UNIT_W-1:0] unit_r;
  logic              eoi_r;
  logic              room, fire, in_acc;
  stl_push_t         push;
  stl_res_t          rd_data;

  assign fire      = in_valid_r & room;
  assign in_tready = ~in_valid_r | room;
  assign in_acc    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      unit_r <= in_tdata;
      eoi_r  <= in_tuser;
    end
  end

  stl_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .unit  (unit_r),
    .eoi   (eoi_r),
    .push  (push)
  );

  stl_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (rd_data)
  );

  assign out_tdata = rd_data.len;
  assign out_tuser = rd_data.kind;
  assign out_tlast = rd_data.last;

endmodule

// ===== tb/token_checker.sv =====
`timescale 1ns / 1ps
module token_checker
  import stl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [UNIT_W-1:0]    in_tdata,   // [15:0] code_unit
  input  logic                 in_tuser,   // [0] end_of_input
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [TOK_LEN_W-1:0] out_tdata,  // [15:0] token_length
  input  logic [3:0]           out_tuser,  // [3:0] tok_kind
  input  logic                 out_tlast,
  output int                   mismatches,
  output int                   waiting,
  output int                   tokens_checked
);

  typedef struct packed {
    kind_t       kind;
    logic [15:0] len;
    logic        last;
  } token_t;

  mode_t       lex_state;
  logic [15:0] run_len;
  token_t      step_tokens[$];
  token_t      tokens_due[$];

  function automatic bit space_unit(input logic [15:0] c);
    return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
           c == 16'h200E || c == 16'h200F || c == 16'h2028 || c == 16'h2029;
  endfunction

  function automatic bit word_unit(input logic [15:0] c);
    return (c >= 16'h0061 && c <= 16'h007A) || (c >= 16'h0041 && c <= 16'h005A) ||
           (c >= 16'h3400 && c <= 16'h4DBF) || (c >= 16'h4E00 && c <= 16'h9FFF) ||
           (c >= 16'hD83C && c <= 16'hDBFF) || (c >= 16'hDC00 && c <= 16'hDFFF);
  endfunction

  function automatic bit digit_unit(input logic [15:0] c);
    return c >= 16'h0030 && c <= 16'h0039;
  endfunction

  task automatic emit_token(input kind_t k, input logic [15:0] n);
    token_t t;
    t.kind = k;
    t.len  = n;
    t.last = 1'b0;
    step_tokens.push_back(t);
  endtask

  task automatic extend();
    if (run_len != 16'hFFFF) run_len = run_len + 16'd1;
  endtask

  task automatic open_token(input logic [15:0] c);
    run_len = 16'd1;
    if (c == CH_SLASH) begin
      lex_state = M_SLASH;
    end else if (space_unit(c)) begin
      lex_state = M_SPACE;
    end else if (c == CH_UNDER || word_unit(c)) begin
      lex_state = M_IDENT;
    end else if (digit_unit(c)) begin
      lex_state = M_LIT;
    end else begin
      lex_state = M_IDLE;
      run_len = '0;
      if (c == CH_SEMI) emit_token(K_SEMI, 16'd1);
      else if (c == CH_COMMA) emit_token(K_COMMA, 16'd1);
      else if (c == CH_OPEN) emit_token(K_OPEN, 16'd1);
      else if (c == CH_CLOSE) emit_token(K_CLOSE, 16'd1);
      else if (c == CH_EQ) emit_token(K_EQ, 16'd1);
      else emit_token(K_UNKNOWN, 16'd1);
    end
  endtask

  task automatic lex_step(input logic [15:0] c, input logic eoi);
    token_t t;
    step_tokens.delete();
    if (eoi) begin
      case (lex_state)
        M_SLASH: emit_token(K_UNKNOWN, 16'd1);
        M_LINE: emit_token(K_LINE, run_len);
        M_BLOCK, M_BLOCK_STAR: emit_token(K_BLOCK, run_len);
        M_SPACE: emit_token(K_SPACE, run_len);
        M_IDENT: emit_token(K_IDENT, run_len);
        M_LIT: emit_token(K_LIT, run_len);
        default: ;
      endcase
      lex_state = M_IDLE;
      run_len = '0;
    end else begin
      case (lex_state)
        M_SLASH: begin
          if (c == CH_SLASH) begin
            lex_state = M_LINE;
            extend();
          end else if (c == CH_STAR) begin
            lex_state = M_BLOCK;
            extend();
          end else begin
            emit_token(K_UNKNOWN, 16'd1);
            open_token(c);
          end
        end
        M_LINE: begin
          if (c == CH_LF) begin
            emit_token(K_LINE, run_len);
            open_token(c);
          end else begin
            extend();
          end
        end
        M_BLOCK: begin
          extend();
          if (c == CH_STAR) lex_state = M_BLOCK_STAR;
        end
        M_BLOCK_STAR: begin
          extend();
          if (c == CH_SLASH) begin
            emit_token(K_BLOCK, run_len);
            lex_state = M_IDLE;
            run_len = '0;
          end else if (c != CH_STAR) begin
            lex_state = M_BLOCK;
          end
        end
        M_SPACE: begin
          if (space_unit(c)) begin
            extend();
          end else begin
            emit_token(K_SPACE, run_len);
            open_token(c);
          end
        end
        M_IDENT: begin
          if (word_unit(c)) begin
            extend();
          end else begin
            // quote or hash right after a name makes it a prefix
            if (c == CH_HASH || c == CH_DQUOTE || c == CH_SQUOTE) emit_token(K_PREFIX, run_len);
            else emit_token(K_IDENT, run_len);
            open_token(c);
          end
        end
        M_LIT: begin
          if (digit_unit(c)) begin
            extend();
          end else begin
            emit_token(K_LIT, run_len);
            open_token(c);
          end
        end
        default: open_token(c);
      endcase
    end
    for (int i = 0; i < step_tokens.size(); i++) begin
      t = step_tokens[i];
      t.last = (i == step_tokens.size() - 1);
      tokens_due.push_back(t);
    end
  endtask

  always @(posedge clk) begin : watch
    token_t want;
    if (!rst_n) begin
      lex_state = M_IDLE;
      run_len = '0;
      tokens_due.delete();
    end else begin
      if (in_tvalid && in_tready) lex_step(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        tokens_checked++;
        if (tokens_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected token kind %0d len %0d last %0b",
                     $realtime, out_tuser, out_tdata, out_tlast);
          mismatches++;
        end else begin
          want = tokens_due.pop_front();
          if (out_tuser !== want.kind || out_tdata !== want.len || out_tlast !== want.last) begin
            if (mismatches < 10)
              $display("%0t: token %0d expected kind %0d len %0d last %0b, got %0d %0d %0b",
                       $realtime, tokens_checked, want.kind, want.len, want.last,
                       out_tuser, out_tdata, out_tlast);
            mismatches++;
          end
        end
      end
    end
    waiting = tokens_due.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import stl_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [UNIT_W-1:0]    in_tdata;   // [15:0] code_unit
  logic                 in_tuser;   // [0] end_of_input
  logic                 out_tvalid;
  logic                 out_tready;
  logic [TOK_LEN_W-1:0] out_tdata;  // [15:0] token_length
  logic [3:0]           out_tuser;  // [3:0] tok_kind
  logic                 out_tlast;

  int mismatches;
  int waiting;
  int tokens_checked;
  int words_sent;
  bit steady;
  bit hold_request;

  source_tokenizer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  token_checker token_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatches     (mismatches),
    .waiting        (waiting),
    .tokens_checked (tokens_checked)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int idle_draw();
    return steady ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [15:0] word_pick();
    case ($urandom_range(0, 5))
      0: return 16'(16'h0061 + $urandom_range(0, 25));
      1: return 16'(16'h0041 + $urandom_range(0, 25));
      2: return 16'($urandom_range(16'h3400, 16'h4DBF));
      3: return 16'($urandom_range(16'h4E00, 16'h9FFF));
      4: return 16'($urandom_range(16'hD83C, 16'hDBFF));
      default: return 16'($urandom_range(16'hDC00, 16'hDFFF));
    endcase
  endfunction

  function automatic logic [15:0] space_pick();
    case ($urandom_range(0, 6))
      0: return 16'($urandom_range(16'h0009, 16'h000D));
      1: return 16'h0020;
      2: return 16'h0085;
      3: return 16'h200E;
      4: return 16'h200F;
      5: return 16'h2028;
      default: return 16'h2029;
    endcase
  endfunction

  // units at the edges of the wide word ranges and just outside the word and space ranges
  function automatic logic [15:0] boundary_pick();
    case ($urandom_range(0, 23))
      0: return 16'h33FF;
      1: return 16'h3400;
      2: return 16'h4DBF;
      3: return 16'h4DC0;
      4: return 16'h4DFF;
      5: return 16'h4E00;
      6: return 16'h9FFF;
      7: return 16'hA000;
      8: return 16'hD83B;
      9: return 16'hD83C;
      10: return 16'hDBFF;
      11: return 16'hDC00;
      12: return 16'hDFFF;
      13: return 16'hE000;
      14: return 16'h0008;
      15: return 16'h000E;
      16: return 16'h001F;
      17: return 16'h0084;
      18: return 16'h200D;
      19: return 16'h202A;
      20: return 16'h0040;
      21: return 16'h005B;
      22: return 16'h0060;
      default: return 16'h007B;
    endcase
  endfunction

  task automatic send_word(input logic [15:0] c, input logic eoi);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_fragment();
    case ($urandom_range(0, 11))
      0, 1: begin
        if ($urandom_range(0, 3) == 0) send_word(CH_UNDER, 1'b0);
        else send_word(word_pick(), 1'b0);
        repeat ($urandom_range(0, 8)) send_word(word_pick(), 1'b0);
        case ($urandom_range(0, 5))
          0: send_word(CH_HASH, 1'b0);
          1: send_word(CH_DQUOTE, 1'b0);
          2: send_word(CH_SQUOTE, 1'b0);
          default: ;
        endcase
      end
      2: repeat ($urandom_range(1, 6)) send_word(16'(16'h0030 + $urandom_range(0, 9)), 1'b0);
      3: repeat ($urandom_range(1, 5)) send_word(space_pick(), 1'b0);
      4: begin
        send_word(CH_SLASH, 1'b0);
        send_word(CH_SLASH, 1'b0);
        repeat ($urandom_range(0, 8)) send_word(16'($urandom_range(0, 16'hFFFF)), 1'b0);
        if ($urandom_range(0, 4) != 0) send_word(CH_LF, 1'b0);
      end
      5: begin
        send_word(CH_SLASH, 1'b0);
        send_word(CH_STAR, 1'b0);
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(0, 3))
            0: send_word(CH_STAR, 1'b0);
            1: send_word(CH_SLASH, 1'b0);
            default: send_word(16'($urandom_range(0, 16'hFFFF)), 1'b0);
          endcase
        end
        // some comments stay open
        if ($urandom_range(0, 4) != 0) begin
          send_word(CH_STAR, 1'b0);
          send_word(CH_SLASH, 1'b0);
        end
      end
      6: begin
        case ($urandom_range(0, 4))
          0: send_word(CH_SEMI, 1'b0);
          1: send_word(CH_COMMA, 1'b0);
          2: send_word(CH_OPEN, 1'b0);
          3: send_word(CH_CLOSE, 1'b0);
          default: send_word(CH_EQ, 1'b0);
        endcase
      end
      7: begin
        send_word(CH_SLASH, 1'b0);
        send_word(16'($urandom_range(0, 16'hFFFF)), 1'b0);
      end
      8: send_word(16'($urandom_range(0, 16'hFFFF)), 1'b0);
      9: send_word(16'($urandom_range(0, 16'hFFFF)), 1'b1);
      default: send_word(boundary_pick(), 1'b0);
    endcase
  endtask

  initial begin : receiver
    int gap;
    bit hold_done;
    out_tready = 1'b0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_done = 1'b1;
      end
      gap = idle_draw();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid || (hold_request && !hold_done))) @(posedge clk);
    end
  end

  initial begin : stimulus
    int start;
    int k;
    bit held;
    bit drained;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    steady       = 1'b0;
    hold_request = 1'b0;
    words_sent   = 0;
    held         = 1'b0;
    drained      = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes, punctuation, lone slash, flushes
    send_word(16'h0000, 1'b1);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(CH_SEMI, 1'b0);
    send_word(CH_COMMA, 1'b0);
    send_word(CH_OPEN, 1'b0);
    send_word(CH_CLOSE, 1'b0);
    send_word(CH_EQ, 1'b0);
    send_word(CH_SLASH, 1'b0);
    send_word(16'h0061, 1'b0);
    send_word(CH_HASH, 1'b0);
    send_word(CH_UNDER, 1'b0);
    send_word(16'h0030, 1'b0);
    send_word(16'h0039, 1'b0);
    send_word(16'h2029, 1'b0);
    send_word(16'h0085, 1'b0);
    send_word(CH_SLASH, 1'b0);
    send_word(16'hFFFF, 1'b1);
    send_word(CH_SLASH, 1'b0);
    send_word(CH_STAR, 1'b0);
    send_word(CH_SLASH, 1'b0);
    send_word(CH_STAR, 1'b0);
    send_word(CH_SLASH, 1'b0);
    send_word(CH_SLASH, 1'b0);
    send_word(CH_SLASH, 1'b0);
    send_word(16'h4E00, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(16'hD83C, 1'b0);
    send_word(16'hDFFF, 1'b0);
    send_word(CH_DQUOTE, 1'b0);
    send_word(CH_SLASH, 1'b0);
    send_word(CH_STAR, 1'b0);
    send_word(16'h0000, 1'b1);

    start = words_sent;
    while (words_sent - start < 1915) begin
      if ($urandom_range(0, 29) == 0) steady = ~steady;
      if (!held && words_sent - start > 500) begin
        hold_request = 1'b1;
        held = 1'b1;
      end
      if (!drained && words_sent - start > 1200) begin
        in_tvalid <= 1'b0;
        do @(negedge clk); while (waiting != 0);
        repeat (4) @(negedge clk);
        drained = 1'b1;
      end
      send_fragment();
    end
    send_word(16'h0000, 1'b1);

    in_tvalid <= 1'b0;
    k = 0;
    do begin
      @(negedge clk);
      k++;
    end while (waiting != 0 && k < 20000);
    repeat (8) @(negedge clk);
    $display("tb: %0d words sent across all token classes and range edges, %0d tokens checked",
             words_sent, tokens_checked);
    $display("tb: random idling, one long output stall and one full drain were exercised");
    if (waiting != 0) $display("tb: %0d tokens never arrived", waiting);
    if (mismatches == 0 && waiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
